// File: rtl/bwb_pkg.sv
// Shared types and constants for the blink waveform brightness pipeline.
package bwb_pkg;

  // Waveform selection codes
  typedef enum logic [1:0] {
    MODE_STEADY = 2'd0,
    MODE_SAW    = 2'd1,
    MODE_TRI    = 2'd2,
    MODE_PULSE  = 2'd3
  } wave_mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL = 3'd5;
  localparam int CFG_DATA_W = 32;

  // Live configuration seen by all stages
  typedef struct packed {
    logic [31:0]        start_tick;
    logic [31:0]        blink_rate;
    logic [16:0]        duty_limit;
    wave_mode_t         wave_mode;
    logic signed [23:0] amplitude;
    logic signed [23:0] base_level;
  } cfg_t;

  // Per-item flags that ride along with the data
  typedef struct packed {
    logic steady;
    logic dark;
    logic pulse;
  } item_flags_t;

  // Scaled shape (amplitude * shape, floored to Q.16) width
  localparam int SCALED_W = 30;

  // Floor divide by ten: bias to non-negative, then reciprocal multiply
  localparam logic signed [SCALED_W:0] DIV_OFS = 31'sd671088640;  // 10 * 2^26
  localparam logic signed [SCALED_W-1:0] QUO_OFS = 30'sd67108864; // 2^26
  localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  // Output range, signed Q9.16
  localparam int BRIGHT_W = 25;
  localparam logic signed [BRIGHT_W-1:0] BRIGHT_ONE = 25'sd65536;
  localparam logic signed [SCALED_W+1:0] SUM_MAX = 32'sd16777215;
  localparam logic signed [SCALED_W+1:0] SUM_MIN = -32'sd16777216;

endpackage

// File: rtl/blink_waveform_brightness.sv
// Throughput: one item per cycle while the output is not stalled; each of the six stages holds one item and the
// stall chain lets a stage load whenever it is empty or its successor loads.
// The two multiplies (rate and amplitude) and the divide-by-ten reciprocal set the stages.
// Reset (synchronous) empties the pipeline and loads register defaults:
// duty 1.0, steady mode, amplitude 1.0, all else zero.
module blink_waveform_brightness #(
  parameter int PHASE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bwb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bwb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [31:0]                         now_tick,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bwb_pkg::BRIGHT_W-1:0] brightness,
  output logic                                dark
);
  import bwb_pkg::*;

  localparam int SW = PHASE_BITS + 5;

  cfg_t                  cfg;
  logic                  ph_valid;
  logic                  ph_stall;
  logic [PHASE_BITS-1:0] phase;
  logic                  sh_valid;
  logic                  sh_stall;
  logic [SW-1:0]         snum;
  item_flags_t           sh_flags;
  logic                  sc_valid;
  logic                  sc_stall;
  logic [SCALED_W-1:0]   scaled;
  item_flags_t           sc_flags;
  logic [2:0]            occ;
  logic                  in_acc;
  logic                  out_acc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_tick <= '0;
      cfg.blink_rate <= '0;
      cfg.duty_limit <= 17'd65536;
      cfg.wave_mode  <= MODE_STEADY;
      cfg.amplitude  <= 24'sd65536;
      cfg.base_level <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_TICK: cfg.start_tick <= cfg_data;
        CFG_BLINK_RATE: cfg.blink_rate <= cfg_data;
        CFG_DUTY_LIMIT: cfg.duty_limit <= cfg_data[16:0];
        CFG_WAVE_MODE:  cfg.wave_mode  <= wave_mode_t'(cfg_data[1:0]);
        CFG_AMPLITUDE:  cfg.amplitude  <= $signed(cfg_data[23:0]);
        CFG_BASE_LEVEL: cfg.base_level <= $signed(cfg_data[23:0]);
        default: ;
      endcase
    end
  end

  bwb_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .now_tick  (now_tick),
    .out_valid (ph_valid),
    .out_stall (ph_stall),
    .phase     (phase)
  );

  bwb_shape #(.PHASE_BITS(PHASE_BITS)) u_shape (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ph_valid),
    .in_stall  (ph_stall),
    .phase     (phase),
    .out_valid (sh_valid),
    .out_stall (sh_stall),
    .snum      (snum),
    .flags     (sh_flags)
  );

  bwb_scale #(.PHASE_BITS(PHASE_BITS)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sh_valid),
    .in_stall  (sh_stall),
    .snum      (snum),
    .in_flags  (sh_flags),
    .out_valid (sc_valid),
    .out_stall (sc_stall),
    .scaled    (scaled),
    .out_flags (sc_flags)
  );

  bwb_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (sc_valid),
    .in_stall   (sc_stall),
    .scaled     (scaled),
    .flags      (sc_flags),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .brightness (brightness),
    .dark       (dark)
  );

  // Items in flight, for checking only
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (in_acc && !out_acc) begin
      occ <= occ + 3'd1;
    end else if (!in_acc && out_acc) begin
      occ <= occ - 3'd1;
    end
  end

  // Six stages hold at most six items
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= 3'd6)
    else $error("more items in flight than pipeline stages");

  // Input stalls only when the output register holds an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // A valid result must belong to an accepted item
  a_out_owned: assert property (@(posedge clk) disable iff (rst) out_valid |-> occ != 3'd0)
    else $error("result presented with no item in flight");

  // Dark results carry zero brightness
  a_dark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dark |-> brightness == '0)
    else $error("dark result with nonzero brightness");

endmodule

// File: rtl/bwb_phase.sv
// Phase stages: elapsed ticks, then fractional part of elapsed * rate.
module bwb_phase #(
  parameter int PHASE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bwb_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           now_tick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PHASE_BITS-1:0] phase
);
  import bwb_pkg::*;

  logic        v_a;
  logic [23:0] elapsed;
  logic        en_a;
  logic        en_b;
  logic [47:0] frac_prod;

  // Stage advance: a stage loads when empty or when its successor loads
  assign en_b     = !out_valid || !out_stall;
  assign en_a     = !v_a || en_b;
  assign in_stall = !en_a;

  // Only the low 24 bits of the product matter, so only 24 bits of each factor
  assign frac_prod = 48'(elapsed) * 48'(cfg.blink_rate[23:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) v_a <= in_valid;
      if (en_b) out_valid <= v_a;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (en_a) elapsed <= now_tick[23:0] - cfg.start_tick[23:0];
    if (en_b) phase <= frac_prod[23 -: PHASE_BITS];
  end

endmodule

// File: rtl/bwb_shape.sv
// Shape stage: duty compare and waveform numerator for the current phase.
module bwb_shape #(
  parameter int PHASE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bwb_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PHASE_BITS-1:0]     phase,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PHASE_BITS+4:0]     snum,
  output bwb_pkg::item_flags_t      flags
);
  import bwb_pkg::*;

  localparam int SW = PHASE_BITS + 5;

  logic              en;
  logic [SW-1:0]     pw;
  logic [SW-1:0]     one_w;
  logic [SW-1:0]     tri2;
  logic [SW-1:0]     snum_next;
  logic [24:0]       p_al;
  logic [24:0]       duty_al;
  item_flags_t       flags_next;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  assign pw    = SW'(phase);
  assign one_w = SW'(1) << PHASE_BITS;
  assign tri2  = pw << 1;

  // Duty compare at 24-bit alignment
  assign p_al    = 25'(phase) << (24 - PHASE_BITS);
  assign duty_al = {cfg.duty_limit, 8'b0};

  // Numerator over one (saw, triangle) or over ten times one (pulse)
  always_comb begin
    snum_next = '0;
    unique case (cfg.wave_mode)
      MODE_STEADY: snum_next = '0;
      MODE_SAW:    snum_next = pw;
      MODE_TRI: begin
        if (tri2 > one_w) snum_next = (one_w << 1) - tri2;
        else snum_next = tri2;
      end
      MODE_PULSE: begin
        priority if (SW'(5) * pw <= (one_w << 1)) snum_next = SW'(25) * pw;
        else if (tri2 < one_w) snum_next = SW'(18) * one_w - SW'(20) * pw;
        else if (SW'(10) * pw < SW'(6) * one_w) snum_next = SW'(20) * pw - (one_w << 1);
        else snum_next = SW'(25) * one_w - SW'(25) * pw;
      end
      default: snum_next = '0;
    endcase
  end

  always_comb begin
    flags_next.steady = (cfg.wave_mode == MODE_STEADY);
    flags_next.dark   = (cfg.wave_mode != MODE_STEADY) && (p_al > duty_al);
    flags_next.pulse  = (cfg.wave_mode == MODE_PULSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snum  <= snum_next;
      flags <= flags_next;
    end
  end

endmodule

// File: rtl/bwb_scale.sv
// Scale stages: amplitude multiply with floor to Q.16, then floor divide by ten for pulse mode.
module bwb_scale #(
  parameter int PHASE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bwb_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PHASE_BITS+4:0]         snum,
  input  bwb_pkg::item_flags_t          in_flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bwb_pkg::SCALED_W-1:0]  scaled,
  output bwb_pkg::item_flags_t          out_flags
);
  import bwb_pkg::*;

  localparam int SW = PHASE_BITS + 5;
  localparam int PW = SW + 1 + 24;

  logic                       v_c;
  logic                       en_c;
  logic                       en_d;
  logic signed [PW-1:0]       prod;
  logic [SCALED_W-1:0]        t_c;
  item_flags_t                flags_c;
  logic signed [SCALED_W:0]   t_x;
  logic signed [SCALED_W:0]   u;
  logic [63:0]                q_prod;

  assign en_d     = !out_valid || !out_stall;
  assign en_c     = !v_c || en_d;
  assign in_stall = !en_c;

  // Amplitude times shape numerator; dropping low bits floors toward minus infinity
  assign prod = $signed({1'b0, snum}) * cfg.amplitude;

  // Biased value is non-negative, so the reciprocal multiply gives the floor
  assign t_x    = {t_c[SCALED_W-1], t_c};
  assign u      = t_x + DIV_OFS;
  assign q_prod = 64'({1'b0, u}) * 64'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_c) v_c <= in_valid;
      if (en_d) out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      t_c     <= prod[PW-1:PHASE_BITS];
      flags_c <= in_flags;
    end
    if (en_d) begin
      // Pulse carries the biased quotient; the bias comes off in the next stage
      scaled    <= flags_c.pulse ? SCALED_W'(q_prod[63:DIV10_SHIFT]) : t_c;
      out_flags <= flags_c;
    end
  end

endmodule

// File: rtl/bwb_out.sv
// Output stage: remove pulse bias, add base level, saturate, select steady or dark, hold result.
module bwb_out (
  input  logic                                clk,
  input  logic                                rst,
  input  bwb_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bwb_pkg::SCALED_W-1:0]        scaled,
  input  bwb_pkg::item_flags_t                flags,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bwb_pkg::BRIGHT_W-1:0] brightness,
  output logic                                dark
);
  import bwb_pkg::*;

  logic                          en;
  logic signed [SCALED_W-1:0]    val_s;
  logic signed [SCALED_W+1:0]    sum;
  logic signed [BRIGHT_W-1:0]    sat;
  logic signed [BRIGHT_W-1:0]    bright_next;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Remove quotient bias for pulse, then add the offset
  assign val_s = flags.pulse ? $signed(scaled) - QUO_OFS : $signed(scaled);
  assign sum   = (SCALED_W+2)'(val_s) + (SCALED_W+2)'(cfg.base_level);

  // Clamp to signed Q9.16
  always_comb begin
    priority if (sum > SUM_MAX) sat = SUM_MAX[BRIGHT_W-1:0];
    else if (sum < SUM_MIN) sat = SUM_MIN[BRIGHT_W-1:0];
    else sat = sum[BRIGHT_W-1:0];
  end

  always_comb begin
    priority if (flags.steady) bright_next = BRIGHT_ONE;
    else if (flags.dark) bright_next = '0;
    else bright_next = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brightness <= bright_next;
      dark       <= flags.dark;
    end
  end

endmodule
